>>> hw/rtl/ttb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_pkg: shared types and constants of the tangent basis unit
// Command/status structs between controller and datapath, cross product
// step codes, corner slot codes and the saturating delta helper.
// ----------------------------------------------------------------------------
package ttb_pkg;

    localparam int unsigned W         = 32;  // field width (Q16.16)
    localparam int unsigned WW        = 64;  // wide product / determinant width
    localparam int unsigned LANES     = 6;   // divide lanes: tangent xyz, bitangent xyz
    localparam int unsigned NCROSS    = 7;   // det + six numerators
    localparam int unsigned DIV_STEPS = 32;  // quotient bits per divide

    // cross product step codes (also the index into the cross result file)
    localparam logic [2:0] X_DET   = 3'd0;
    localparam logic [2:0] X_TAN_X = 3'd1;
    localparam logic [2:0] X_TAN_Y = 3'd2;
    localparam logic [2:0] X_TAN_Z = 3'd3;
    localparam logic [2:0] X_BIT_X = 3'd4;
    localparam logic [2:0] X_BIT_Y = 3'd5;
    localparam logic [2:0] X_BIT_Z = 3'd6;

    // corner slot codes
    localparam logic [1:0] SLOT_C0 = 2'd0;
    localparam logic [1:0] SLOT_C1 = 2'd1;
    localparam logic [1:0] SLOT_C2 = 2'd2;

    typedef struct packed {
        logic       corner_load;
        logic [1:0] slot;
        logic       delta_load;
        logic       mul_go;
        logic [2:0] mul_sel;
        logic       wb_go;
        logic [2:0] wb_sel;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic det_zero;
    } t_status;

    // a - b, both signed 32-bit, saturated to signed 32 bits
    function automatic logic [W-1:0] sat_delta(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] d;
        d = {a[W-1], a} - {b[W-1], b};
        if (d[W] != d[W-1]) begin
            sat_delta = d[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            sat_delta = d[W-1:0];
        end
    endfunction

endpackage

>>> hw/rtl/ttb_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_div_lane: one restoring divide lane
// Computes (num * 2^16) / den, truncated toward zero, one quotient bit per
// step, then saturates the signed result to 32 bits.
// ----------------------------------------------------------------------------
module ttb_div_lane (
    input  logic                   i_clk,
    input  logic                   i_init,
    input  logic                   i_step,
    input  logic [ttb_pkg::WW-1:0] i_num,
    input  logic [ttb_pkg::WW-1:0] i_den,      // magnitude of the determinant
    input  logic                   i_den_neg,
    output logic [ttb_pkg::W-1:0]  o_q
);

    logic [ttb_pkg::WW-1:0] n_abs;
    logic [ttb_pkg::WW:0]   t;
    logic [ttb_pkg::WW:0]   diff;
    logic                   ge;

    logic [ttb_pkg::WW-1:0] r_rem;
    logic [ttb_pkg::W-1:0]  r_low;
    logic [ttb_pkg::W-1:0]  r_quo;
    logic                   r_neg;
    logic                   r_sat;

    assign n_abs = i_num[ttb_pkg::WW-1] ? (ttb_pkg::WW'(0) - i_num) : i_num;
    assign t     = {r_rem, r_low[ttb_pkg::W-1]};
    assign diff  = t - {1'b0, i_den};
    assign ge    = (t >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_neg <= i_num[ttb_pkg::WW-1] ^ i_den_neg;
            // quotient would reach 2^32 when num >= den * 2^16
            r_sat <= (i_den[63:48] == 16'd0) && (n_abs >= {i_den[47:0], 16'd0});
            r_rem <= {16'd0, n_abs[63:16]};
            r_low <= {n_abs[15:0], 16'd0};
            r_quo <= '0;
        end else if (i_step) begin
            r_rem <= ge ? diff[ttb_pkg::WW-1:0] : t[ttb_pkg::WW-1:0];
            r_low <= {r_low[ttb_pkg::W-2:0], 1'b0};
            r_quo <= {r_quo[ttb_pkg::W-2:0], ge};
        end
    end

    always_comb begin
        if (r_neg) begin
            if (r_sat || (r_quo > 32'h8000_0000)) begin
                o_q = 32'h8000_0000;
            end else begin
                o_q = 32'd0 - r_quo;
            end
        end else begin
            if (r_sat || r_quo[ttb_pkg::W-1]) begin
                o_q = 32'h7FFF_FFFF;
            end else begin
                o_q = r_quo;
            end
        end
    end

endmodule

>>> hw/rtl/ttb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_datapath: corner store, deltas, cross products, divide lanes, output
// Two 32x32 multipliers form one a*b - c*d term per step; six lanes divide
// the numerators by the determinant in parallel.
// ----------------------------------------------------------------------------
module ttb_datapath (
    input  logic                  i_clk,
    input  ttb_pkg::t_cmd         i_cmd,
    output ttb_pkg::t_status      o_status,
    input  logic [ttb_pkg::W-1:0] i_pos_x,
    input  logic [ttb_pkg::W-1:0] i_pos_y,
    input  logic [ttb_pkg::W-1:0] i_pos_z,
    input  logic [ttb_pkg::W-1:0] i_tex_u,
    input  logic [ttb_pkg::W-1:0] i_tex_v,
    output logic [ttb_pkg::W-1:0] o_tangent_x,
    output logic [ttb_pkg::W-1:0] o_tangent_y,
    output logic [ttb_pkg::W-1:0] o_tangent_z,
    output logic [ttb_pkg::W-1:0] o_bitangent_x,
    output logic [ttb_pkg::W-1:0] o_bitangent_y,
    output logic [ttb_pkg::W-1:0] o_bitangent_z,
    output logic                  o_degenerate
);

    // held corners 0 and 1, third corner
    logic [ttb_pkg::W-1:0] r_h_px [2];
    logic [ttb_pkg::W-1:0] r_h_py [2];
    logic [ttb_pkg::W-1:0] r_h_pz [2];
    logic [ttb_pkg::W-1:0] r_h_tu [2];
    logic [ttb_pkg::W-1:0] r_h_tv [2];
    logic [ttb_pkg::W-1:0] r_c2_px, r_c2_py, r_c2_pz, r_c2_tu, r_c2_tv;

    // saturated deltas
    logic signed [ttb_pkg::W-1:0] r_e0 [3];
    logic signed [ttb_pkg::W-1:0] r_e1 [3];
    logic signed [ttb_pkg::W-1:0] r_du0, r_dv0, r_du1, r_dv1;

    // multiplier operands and products
    logic signed [ttb_pkg::W-1:0]  m_a, m_b, m_c, m_d;
    logic signed [ttb_pkg::WW-1:0] prod_ab, prod_cd;
    logic signed [ttb_pkg::WW-1:0] r_pa, r_pb;
    logic [ttb_pkg::WW-1:0]        r_cross [ttb_pkg::NCROSS];

    logic [ttb_pkg::WW-1:0] r_den_abs;
    logic                   r_den_neg;
    logic [ttb_pkg::W-1:0]  lane_q [ttb_pkg::LANES];

    logic [ttb_pkg::W-1:0] r_o_tx, r_o_ty, r_o_tz, r_o_bx, r_o_by, r_o_bz;
    logic                  r_o_dg;

    // corner capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.corner_load) begin
            if (i_cmd.slot == ttb_pkg::SLOT_C0 || i_cmd.slot == ttb_pkg::SLOT_C1) begin
                r_h_px[i_cmd.slot[0]] <= i_pos_x;
                r_h_py[i_cmd.slot[0]] <= i_pos_y;
                r_h_pz[i_cmd.slot[0]] <= i_pos_z;
                r_h_tu[i_cmd.slot[0]] <= i_tex_u;
                r_h_tv[i_cmd.slot[0]] <= i_tex_v;
            end else begin
                r_c2_px <= i_pos_x;
                r_c2_py <= i_pos_y;
                r_c2_pz <= i_pos_z;
                r_c2_tu <= i_tex_u;
                r_c2_tv <= i_tex_v;
            end
        end
    end

    // edges and UV deltas relative to corner 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.delta_load) begin
            r_e0[0] <= ttb_pkg::sat_delta(r_h_px[1], r_h_px[0]);
            r_e0[1] <= ttb_pkg::sat_delta(r_h_py[1], r_h_py[0]);
            r_e0[2] <= ttb_pkg::sat_delta(r_h_pz[1], r_h_pz[0]);
            r_e1[0] <= ttb_pkg::sat_delta(r_c2_px, r_h_px[0]);
            r_e1[1] <= ttb_pkg::sat_delta(r_c2_py, r_h_py[0]);
            r_e1[2] <= ttb_pkg::sat_delta(r_c2_pz, r_h_pz[0]);
            r_du0   <= ttb_pkg::sat_delta(r_h_tu[1], r_h_tu[0]);
            r_dv0   <= ttb_pkg::sat_delta(r_h_tv[1], r_h_tv[0]);
            r_du1   <= ttb_pkg::sat_delta(r_c2_tu, r_h_tu[0]);
            r_dv1   <= ttb_pkg::sat_delta(r_c2_tv, r_h_tv[0]);
        end
    end

    // operand select: term = a*b - c*d
    always_comb begin
        unique case (i_cmd.mul_sel)
            ttb_pkg::X_DET: begin
                m_a = r_du0; m_b = r_dv1; m_c = r_du1; m_d = r_dv0;
            end
            ttb_pkg::X_TAN_X: begin
                m_a = r_dv1; m_b = r_e0[0]; m_c = r_dv0; m_d = r_e1[0];
            end
            ttb_pkg::X_TAN_Y: begin
                m_a = r_dv1; m_b = r_e0[1]; m_c = r_dv0; m_d = r_e1[1];
            end
            ttb_pkg::X_TAN_Z: begin
                m_a = r_dv1; m_b = r_e0[2]; m_c = r_dv0; m_d = r_e1[2];
            end
            ttb_pkg::X_BIT_X: begin
                m_a = r_du0; m_b = r_e1[0]; m_c = r_du1; m_d = r_e0[0];
            end
            ttb_pkg::X_BIT_Y: begin
                m_a = r_du0; m_b = r_e1[1]; m_c = r_du1; m_d = r_e0[1];
            end
            ttb_pkg::X_BIT_Z: begin
                m_a = r_du0; m_b = r_e1[2]; m_c = r_du1; m_d = r_e0[2];
            end
            default: begin
                m_a = '0; m_b = '0; m_c = '0; m_d = '0;
            end
        endcase
    end

    // signed 32x32 products, operands sign-extended to the product width
    assign prod_ab = ttb_pkg::WW'(m_a) * ttb_pkg::WW'(m_b);
    assign prod_cd = ttb_pkg::WW'(m_c) * ttb_pkg::WW'(m_d);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            r_pa <= prod_ab;
            r_pb <= prod_cd;
        end
        if (i_cmd.wb_go) begin
            r_cross[i_cmd.wb_sel] <= r_pa - r_pb;   // wraps mod 2^64
        end
        r_den_neg <= r_cross[ttb_pkg::X_DET][ttb_pkg::WW-1];
        r_den_abs <= r_cross[ttb_pkg::X_DET][ttb_pkg::WW-1]
                   ? (ttb_pkg::WW'(0) - r_cross[ttb_pkg::X_DET])
                   : r_cross[ttb_pkg::X_DET];
    end

    assign o_status.det_zero = (r_cross[ttb_pkg::X_DET] == '0);

    // lane i divides the numerator at cross index i+1
    for (genvar gi = 0; gi < ttb_pkg::LANES; gi++) begin : g_lane
        ttb_div_lane u_lane (
            .i_clk     (i_clk),
            .i_init    (i_cmd.div_init),
            .i_step    (i_cmd.div_step),
            .i_num     (r_cross[gi + 1]),
            .i_den     (r_den_abs),
            .i_den_neg (r_den_neg),
            .o_q       (lane_q[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (o_status.det_zero) begin
                r_o_tx <= '0; r_o_ty <= '0; r_o_tz <= '0;
                r_o_bx <= '0; r_o_by <= '0; r_o_bz <= '0;
                r_o_dg <= 1'b1;
            end else begin
                r_o_tx <= lane_q[0];
                r_o_ty <= lane_q[1];
                r_o_tz <= lane_q[2];
                r_o_bx <= lane_q[3];
                r_o_by <= lane_q[4];
                r_o_bz <= lane_q[5];
                r_o_dg <= 1'b0;
            end
        end
    end

    assign o_tangent_x   = r_o_tx;
    assign o_tangent_y   = r_o_ty;
    assign o_tangent_z   = r_o_tz;
    assign o_bitangent_x = r_o_bx;
    assign o_bitangent_y = r_o_by;
    assign o_bitangent_z = r_o_bz;
    assign o_degenerate  = r_o_dg;

endmodule

>>> hw/rtl/ttb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_ctrl: sequencing state machine
// Counts corners, steps the cross products and the divide, owns the
// output valid flag.
// ----------------------------------------------------------------------------
module ttb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  ttb_pkg::t_status i_status,
    output ttb_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DELTA,
        S_MUL,
        S_DRAIN,
        S_PREP,
        S_DIV,
        S_FIN
    } t_state;

    localparam logic [4:0] DIV_LAST = 5'(ttb_pkg::DIV_STEPS - 1);

    t_state     r_state;
    logic [1:0] r_cnt;
    logic [2:0] r_step;
    logic [4:0] r_bit;
    logic       r_out_vld;
    logic       in_acc;
    logic       third;

    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign third       = (r_cnt >= ttb_pkg::SLOT_C2);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

    always_comb begin
        o_cmd             = '0;
        o_cmd.corner_load = in_acc;
        o_cmd.slot        = third ? ttb_pkg::SLOT_C2 : r_cnt;
        o_cmd.delta_load  = (r_state == S_DELTA);
        o_cmd.mul_go      = (r_state == S_MUL);
        o_cmd.mul_sel     = r_step;
        o_cmd.wb_go       = ((r_state == S_MUL) && (r_step != ttb_pkg::X_DET))
                          || (r_state == S_DRAIN);
        o_cmd.wb_sel      = r_step - 3'd1;
        o_cmd.div_init    = (r_state == S_PREP);
        o_cmd.div_step    = (r_state == S_DIV);
        o_cmd.out_load    = (r_state == S_FIN) && (!r_out_vld || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_step    <= '0;
            r_bit     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (third) begin
                            r_cnt   <= '0;
                            r_state <= S_DELTA;
                        end else begin
                            r_cnt <= r_cnt + 2'd1;
                        end
                    end
                end
                S_DELTA: begin
                    r_step  <= ttb_pkg::X_DET;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == ttb_pkg::X_BIT_Z) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_bit   <= '0;
                    r_state <= i_status.det_zero ? S_FIN : S_DIV;
                end
                S_DIV: begin
                    r_bit <= r_bit + 5'd1;
                    if (r_bit == DIV_LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (o_cmd.out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (o_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    a_third_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && third) |=> (r_state == S_DELTA && r_cnt == 2'd0))
        else $error("third corner did not start a face computation");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_bit == DIV_LAST) |=> (r_state == S_FIN))
        else $error("divide did not finish after its last quotient bit");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("corner count out of range");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (o_out_valid && r_state == S_IDLE))
        else $error("result load not followed by valid output");

endmodule

>>> hw/rtl/triangle_tangent_basis_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_basis_unit: tangent / bitangent from triangle UVs
// Takes corners one request at a time; every third corner yields one result.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                  | Payload
//  --------+----------------------------+-----------------------------------
//  in      | i_in_valid / o_in_ready    | i_pos_x/y/z, i_tex_u/v (Q16.16)
//  out     | o_out_valid / i_out_ready  | o_tangent_x/y/z, o_bitangent_x/y/z,
//          |                            | o_degenerate
//
//  Sequence: the first and second corner of a face are stored on accept. The
//  third runs through accept, delta, 7 cross product steps on the shared
//  pair of 32x32 multipliers, drain, divide setup, 32 quotient bits in
//  the six parallel restoring divide lanes and the output load. A zero
//  determinant skips the divide.
//  Reset: synchronous, active low; clears the corner count, the sequencer
//  and the output valid flag. Held corners need no reset.
//  Stalls: the result sits in an output register; corners of the next face
//  are taken while it waits. Only a finished face stalls, in its load step,
//  while the previous result is still unread.
//
module triangle_tangent_basis_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // corner requests
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ttb_pkg::W-1:0] i_pos_x,
    input  logic [ttb_pkg::W-1:0] i_pos_y,
    input  logic [ttb_pkg::W-1:0] i_pos_z,
    input  logic [ttb_pkg::W-1:0] i_tex_u,
    input  logic [ttb_pkg::W-1:0] i_tex_v,
    // results
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [ttb_pkg::W-1:0] o_tangent_x,
    output logic [ttb_pkg::W-1:0] o_tangent_y,
    output logic [ttb_pkg::W-1:0] o_tangent_z,
    output logic [ttb_pkg::W-1:0] o_bitangent_x,
    output logic [ttb_pkg::W-1:0] o_bitangent_y,
    output logic [ttb_pkg::W-1:0] o_bitangent_z,
    output logic                  o_degenerate
);

    // controller -> datapath commands, datapath -> controller status
    ttb_pkg::t_cmd    cmd;
    ttb_pkg::t_status status;

    ttb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // corner store, saturated deltas, a*b - c*d terms, divide lanes,
    // output register
    ttb_datapath u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_tex_u       (i_tex_u),
        .i_tex_v       (i_tex_v),
        .o_tangent_x   (o_tangent_x),
        .o_tangent_y   (o_tangent_y),
        .o_tangent_z   (o_tangent_z),
        .o_bitangent_x (o_bitangent_x),
        .o_bitangent_y (o_bitangent_y),
        .o_bitangent_z (o_bitangent_z),
        .o_degenerate  (o_degenerate)
    );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for triangle_tangent_basis_unit
// Sends triangle corners through the request channel and checks every
// tangent / bitangent result against a bit-accurate Q16.16 predictor.
// Covers directed edge cases, random faces, output back-pressure and idle
// pauses with the pipeline drained.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned W = ttb_pkg::W;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 2000000; // far above the slowest legal run
    localparam int DRAIN_CYCLES = 60;      // idle wait after the last result is read
    localparam int PRINT_LIMIT  = 100;     // mismatch lines printed at most

    // Q16.16 values used by the directed faces
    localparam logic [W-1:0] Q_ONE = 32'h0001_0000;
    localparam logic [W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [W-1:0] Q_MIN = 32'h8000_0000;

    // one corner request, field order matches the port list
    typedef struct packed {
        logic [W-1:0] pos_x;
        logic [W-1:0] pos_y;
        logic [W-1:0] pos_z;
        logic [W-1:0] tex_u;
        logic [W-1:0] tex_v;
    } t_corner;

    // one result; the six vectors first so field k sits at [W*(6-k) -: W]
    typedef struct packed {
        logic [W-1:0] tan_x;
        logic [W-1:0] tan_y;
        logic [W-1:0] tan_z;
        logic [W-1:0] bitan_x;
        logic [W-1:0] bitan_y;
        logic [W-1:0] bitan_z;
        logic         degenerate;
    } t_basis;

    // ------------------------------------------------------------------------
    // DUT signals, inputs driven to known values from time zero
    // ------------------------------------------------------------------------
    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_in_valid = 1'b0;
    logic         o_in_ready;
    logic [W-1:0] i_pos_x    = '0;
    logic [W-1:0] i_pos_y    = '0;
    logic [W-1:0] i_pos_z    = '0;
    logic [W-1:0] i_tex_u    = '0;
    logic [W-1:0] i_tex_v    = '0;
    logic         o_out_valid;
    logic         i_out_ready = 1'b0;
    logic [W-1:0] o_tangent_x;
    logic [W-1:0] o_tangent_y;
    logic [W-1:0] o_tangent_z;
    logic [W-1:0] o_bitangent_x;
    logic [W-1:0] o_bitangent_y;
    logic [W-1:0] o_bitangent_z;
    logic         o_degenerate;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_corner     face_corner[2];       // first two corners of the open face
    int          held_count = 0;       // corners taken of the open face
    t_basis      expected_basis[$];    // predicted results, oldest first
    int          error_count = 0;
    int          result_count = 0;
    int unsigned cycle_count = 0;

    // idle control: steady flags switch idling off for a stretch;
    // rx_hold_cycles forces a long read hold-off
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int          rx_hold_cycles = 0;
    int          rx_stall = 0;

    string       vec_name[6] = '{"tangent_x", "tangent_y", "tangent_z",
                                 "bitangent_x", "bitangent_y", "bitangent_z"};

    triangle_tangent_basis_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_tex_u       (i_tex_u),
        .i_tex_v       (i_tex_v),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_tangent_x   (o_tangent_x),
        .o_tangent_y   (o_tangent_y),
        .o_tangent_z   (o_tangent_z),
        .o_bitangent_x (o_bitangent_x),
        .o_bitangent_y (o_bitangent_y),
        .o_bitangent_z (o_bitangent_z),
        .o_degenerate  (o_degenerate)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // a - b as signed 32-bit values, clamped to the signed 32-bit range
    function automatic longint sat_diff(logic [W-1:0] a, logic [W-1:0] b);
        longint d;
        d = longint'($signed(a)) - longint'($signed(b));
        if (d > 64'sd2147483647) begin
            d = 64'sd2147483647;
        end else if (d < -64'sd2147483648) begin
            d = -64'sd2147483648;
        end
        return d;
    endfunction

    // a*b - c*d, kept modulo 2^64
    function automatic logic [63:0] cross_wrap(longint a, longint b, longint c, longint d);
        return a * b - c * d;
    endfunction

    // (num << 16) / den in magnitude, truncated toward zero, clamped to 32 bits.
    // Integer part first, then 16 fraction bits by long division of the remainder.
    function automatic logic [W-1:0] q16_divide(logic [63:0] num, logic [63:0] den);
        logic        num_neg;
        logic        den_neg;
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] frac;
        logic [63:0] mag;
        int          i;
        num_neg = num[63];
        den_neg = den[63];
        n    = num_neg ? 64'd0 - num : num;
        d    = den_neg ? 64'd0 - den : den;
        quo  = n / d;
        rem  = n % d;
        frac = '0;
        for (i = 0; i < 16; i++) begin
            rem  = rem << 1;
            frac = frac << 1;
            if (rem >= d) begin
                rem     = rem - d;
                frac[0] = 1'b1;
            end
        end
        mag = (quo >= 64'h1_0000) ? 64'h1_0000_0000 : ((quo << 16) | frac);
        if (num_neg != den_neg) begin
            if (mag > 64'h8000_0000) begin
                mag = 64'h8000_0000;
            end
            mag = 64'd0 - mag;
        end else if (mag > 64'h7FFF_FFFF) begin
            mag = 64'h7FFF_FFFF;
        end
        return mag[W-1:0];
    endfunction

    // Tangent basis of one face. Edges and UV deltas are taken from the
    // first corner; a zero determinant gives the degenerate flag and zeros.
    function automatic t_basis predict_basis(t_corner c0, t_corner c1, t_corner c2);
        logic [W-1:0] p0[3];
        logic [W-1:0] p1[3];
        logic [W-1:0] p2[3];
        logic [W-1:0] tan_q[3];
        logic [W-1:0] bitan_q[3];
        longint       e0;
        longint       e1;
        longint       du0;
        longint       dv0;
        longint       du1;
        longint       dv1;
        logic [63:0]  det;
        t_basis       b;
        int           k;
        p0  = '{c0.pos_x, c0.pos_y, c0.pos_z};
        p1  = '{c1.pos_x, c1.pos_y, c1.pos_z};
        p2  = '{c2.pos_x, c2.pos_y, c2.pos_z};
        du0 = sat_diff(c1.tex_u, c0.tex_u);
        dv0 = sat_diff(c1.tex_v, c0.tex_v);
        du1 = sat_diff(c2.tex_u, c0.tex_u);
        dv1 = sat_diff(c2.tex_v, c0.tex_v);
        det = cross_wrap(du0, dv1, du1, dv0);
        b   = '0;
        if (det == 64'd0) begin
            b.degenerate = 1'b1;
            return b;
        end
        for (k = 0; k < 3; k++) begin
            e0         = sat_diff(p1[k], p0[k]);
            e1         = sat_diff(p2[k], p0[k]);
            tan_q[k]   = q16_divide(cross_wrap(dv1, e0, dv0, e1), det);
            bitan_q[k] = q16_divide(cross_wrap(du0, e1, du1, e0), det);
        end
        b.tan_x   = tan_q[0];
        b.tan_y   = tan_q[1];
        b.tan_z   = tan_q[2];
        b.bitan_x = bitan_q[0];
        b.bitan_y = bitan_q[1];
        b.bitan_z = bitan_q[2];
        return b;
    endfunction

    // Follows the corner count of the block: two corners are held, the
    // third closes the face and queues its expected result.
    task automatic track_corner(t_corner c);
        if (held_count < 2) begin
            face_corner[held_count] = c;
            held_count++;
        end else begin
            expected_basis.insert(expected_basis.size(),
                                  predict_basis(face_corner[0], face_corner[1], c));
            held_count = 0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Idle lengths: mostly short, a few long
    // ------------------------------------------------------------------------
    function automatic int pick_idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 94) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_gap();
        if (tx_steady || $urandom_range(0, 99) < 60) begin
            return 0;
        end
        return pick_idle_len();
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offers one corner, optionally after a gap, and returns in the time
    // step of acceptance. Valid stays high when the next corner follows
    // without a gap, so valid sees one assignment per step.
    task automatic send_corner(t_corner c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pos_x    <= c.pos_x;
        i_pos_y    <= c.pos_y;
        i_pos_z    <= c.pos_z;
        i_tex_u    <= c.tex_u;
        i_tex_v    <= c.tex_v;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        track_corner(c);
    endtask

    task automatic send_face(t_corner c0, t_corner c1, t_corner c2);
        send_corner(c0);
        send_corner(c1);
        send_corner(c2);
    endtask

    // drop valid and wait until every queued result has been read
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_basis.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic t_corner mk_corner(logic [W-1:0] x, logic [W-1:0] y,
                                          logic [W-1:0] z, logic [W-1:0] u,
                                          logic [W-1:0] v);
        return {x, y, z, u, v};
    endfunction

    // Field value: small geometry-like Q16.16, full range, boundary values,
    // or equal / close to the first corner so deltas become zero or tiny.
    function automatic logic [W-1:0] rand_field(logic [W-1:0] anchor);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
        end else if (r < 60) begin
            return $urandom();
        end else if (r < 72) begin
            case ($urandom_range(0, 5))
                0: return Q_MAX;
                1: return Q_MIN;
                2: return 32'h0000_0000;
                3: return 32'h0000_0001;
                4: return 32'hFFFF_FFFF;
                default: return Q_ONE;
            endcase
        end else if (r < 82) begin
            return anchor;
        end
        return anchor + ($urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000);
    endfunction

    function automatic t_corner random_corner(t_corner anchor);
        return mk_corner(rand_field(anchor.pos_x), rand_field(anchor.pos_y),
                         rand_field(anchor.pos_z), rand_field(anchor.tex_u),
                         rand_field(anchor.tex_v));
    endfunction

    // Random face; one in five gets a collapsed UV layout (third corner on
    // the second or the first corner in UV) to hit a zero determinant.
    task automatic random_face();
        t_corner c0;
        t_corner c1;
        t_corner c2;
        int unsigned r;
        c0 = random_corner('0);
        c1 = random_corner(c0);
        c2 = random_corner(c0);
        r  = $urandom_range(0, 9);
        if (r == 0) begin
            c2.tex_u = c1.tex_u;
            c2.tex_v = c1.tex_v;
        end else if (r == 1) begin
            c2.tex_u = c0.tex_u;
            c2.tex_v = c0.tex_v;
        end
        send_face(c0, c1, c2);
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Read ready with random stalls; a forced hold-off overrides everything
    always @(posedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            i_out_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_out_ready <= 1'b0;
        end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
            rx_stall = pick_idle_len() - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("ERROR @%0t result %0d: %s", $time, result_count, msg);
        end
        error_count++;
    endtask

    // Compare every accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_basis got;
        t_basis want;
        int     k;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_tangent_x, o_tangent_y, o_tangent_z,
                   o_bitangent_x, o_bitangent_y, o_bitangent_z, o_degenerate};
            if (expected_basis.size() == 0) begin
                report_mismatch("result with no face pending");
            end else begin
                want = expected_basis.pop_front();
                for (k = 0; k < 6; k++) begin
                    if (got[W*(6-k) -: W] !== want[W*(6-k) -: W]) begin
                        report_mismatch($sformatf("%s got %h want %h", vec_name[k],
                                                  got[W*(6-k) -: W], want[W*(6-k) -: W]));
                    end
                end
                if (got.degenerate !== want.degenerate) begin
                    report_mismatch($sformatf("degenerate got %b want %b",
                                              got.degenerate, want.degenerate));
                end
            end
            result_count++;
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_basis.size());
            $display("** triangle_tangent_basis_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked faces: all zero, unit triangle, saturating edge and UV
    // deltas both ways, collinear UVs, quotient clamping both ways and
    // fractional results truncated toward zero.
    task automatic test_directed_faces();
        // all corners at the origin: zero determinant
        send_face('0, '0, '0);
        // unit right triangle, tangent along x, bitangent along y
        send_face('0, mk_corner(Q_ONE, 0, 0, Q_ONE, 0),
                  mk_corner(0, Q_ONE, 0, 0, Q_ONE));
        // deltas clamp high
        send_face(mk_corner(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN),
                  mk_corner(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN),
                  mk_corner(Q_MAX, 0, Q_MIN, 0, Q_MAX));
        // deltas clamp low
        send_face(mk_corner(Q_MAX, Q_MAX, 0, Q_MAX, Q_MAX),
                  mk_corner(Q_MIN, 0, Q_MIN, Q_MIN, 32'h1234_5678),
                  mk_corner(32'hFFFF_FFFF, Q_MIN, Q_MAX, 32'h0000_0001, Q_MIN));
        // collinear UVs, nonzero positions: zero determinant
        send_face(mk_corner(Q_ONE, 2 * Q_ONE, 3 * Q_ONE, Q_ONE, Q_ONE),
                  mk_corner(32'hFFFE_0000, Q_ONE, 0, 3 * Q_ONE, 5 * Q_ONE),
                  mk_corner(4 * Q_ONE, 0, 32'hFFFF_8000, 2 * Q_ONE, 3 * Q_ONE));
        // determinant of one lsb: quotients clamp both ways
        send_face('0, mk_corner(Q_MAX, 32'h4000_0000, 1, 1, 0),
                  mk_corner(0, Q_MIN, Q_MAX, 0, 1));
        // same with a negative determinant
        send_face('0, mk_corner(Q_MAX, 32'h4000_0000, 1, 1, 0),
                  mk_corner(0, Q_MIN, Q_MAX, 0, 32'hFFFF_FFFF));
        // mixed signs with fractional quotients
        send_face(mk_corner(32'h0003_8000, 32'hFFFE_4000, 32'h0000_0007,
                            32'h0001_8000, 32'hFFFF_0000),
                  mk_corner(32'hFFFA_1234, 32'h0002_0001, 32'h0010_0000,
                            32'h0004_0000, 32'h0000_5555),
                  mk_corner(32'h0000_0003, 32'hFFFF_FFF9, 32'hFFF0_0000,
                            32'hFFFE_AAAB, 32'h0003_0000));
    endtask

    // Random faces; idling on each side switches off for some stretches
    task automatic test_random_faces(int faces);
        int i;
        for (i = 0; i < faces; i++) begin
            if (i % 25 == 0) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            random_face();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Reader holds off for a long stretch while corners keep coming: the
    // output register and the load step fill up and the request side stalls.
    task automatic test_output_backpressure();
        tx_steady      = 1'b1;
        rx_hold_cycles = 400;
        repeat (40) random_face();
        tx_steady      = 1'b0;
    endtask

    // Sender pauses with the pipeline empty, once between faces and once
    // with a single corner held inside the block.
    task automatic test_drain_pause();
        t_corner c0;
        t_corner c1;
        t_corner c2;
        repeat (10) random_face();
        wait_drain();
        c0 = random_corner('0);
        c1 = random_corner(c0);
        c2 = random_corner(c0);
        send_corner(c0);
        wait_drain();
        send_corner(c1);
        send_corner(c2);
        repeat (9) random_face();
    endtask

    // A lone corner at the end of the run yields nothing
    task automatic test_partial_face();
        send_corner(random_corner('0));
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_faces();
        test_random_faces(420);
        test_output_backpressure();
        test_drain_pause();
        test_random_faces(145);
        test_partial_face();

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_basis.size() == 0) begin
            $display("** triangle_tangent_basis_unit: PASSED **");
        end else begin
            $display("** triangle_tangent_basis_unit: FAILED **");
        end
        $finish;
    end

endmodule
